// File: design/kat_pkg.sv
// Types and codes shared by the keyed alert table and its checker.
// No dependencies.
`timescale 1ns / 1ps

package kat_pkg;

   // Request kinds carried in req_type.
   typedef enum logic [1:0] {
      REQ_REPORT   = 2'd0,
      REQ_SUPPRESS = 2'd1,
      REQ_READ     = 2'd2,
      REQ_SOFT     = 2'd3
   } request_kind_type;

   // Outcome codes carried in rsp_outcome.
   typedef enum logic [3:0] {
      OUT_IGNORED      = 4'd0,
      OUT_INSERTED     = 4'd1,
      OUT_UPDATED      = 4'd2,
      OUT_REMOVED      = 4'd3,
      OUT_CLEAR_ABSENT = 4'd4,
      OUT_HELD         = 4'd5,
      OUT_SUPPRESS_SET = 4'd6,
      OUT_READ_OK      = 4'd7,
      OUT_READ_EMPTY   = 4'd8,
      OUT_SOFT_RESET   = 4'd9
   } outcome_type;

   localparam int CODE_W = 5;
   localparam int SEV_W  = 2;
   localparam int SEQ_W  = 32;
   localparam int TIME_W = 11;
   localparam int SLOT_W = 4;
   localparam int CNT_OUT_W = 5;

   // One table entry.
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [SEV_W-1:0]  severity;
      logic [SEQ_W-1:0]  sequence_num;
      logic              time_known;
      logic [TIME_W-1:0] arrival_time;
   } entry_type;

   // One accepted request word.
   typedef struct packed {
      request_kind_type  kind;
      logic [CODE_W-1:0] alert_code;
      logic              active;
      logic [SEV_W-1:0]  severity;
      logic              time_synced;
      logic [TIME_W-1:0] time_of_day;
      logic [SLOT_W-1:0] read_slot;
   } request_type;

   // One result word.
   typedef struct packed {
      outcome_type          outcome;
      logic                 evicted;
      logic [SLOT_W-1:0]    slot;
      entry_type            entry;
      logic [CNT_OUT_W-1:0] fill_level;
   } result_type;

endpackage

// File: design/kat_lookup.sv
// Parallel code lookup over the occupied slots of the alert table.
// Depends on kat_pkg for the entry type.
`timescale 1ns / 1ps

module kat_lookup
   import kat_pkg::*;
#(
   parameter int CAPACITY = 16,
   parameter int IDX_W    = 4,
   parameter int CNT_W    = 5
) (
   input  entry_type         entries [CAPACITY],
   input  logic [CNT_W-1:0]  count,
   input  logic [CODE_W-1:0] code,
   output logic              hit,
   output logic [IDX_W-1:0]  pos
);

   logic [CAPACITY-1:0] match;

   // Compare every occupied slot against the code at once.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match[i] = (CNT_W'(i) < count) && (entries[i].code == code);
      end
   end

   // Lowest matching slot wins; codes are unique so at most one matches.
   always_comb begin
      pos = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (match[i]) begin
            pos = IDX_W'(i);
         end
      end
      hit = |match;
   end

endmodule

// File: design/keyed_alert_table.sv
// Top level of the keyed alert table: request register, table update and result register.
// Depends on kat_pkg and kat_lookup.
`timescale 1ns / 1ps

// The table takes one request word in every clock cycle: a word is taken at a
// rising edge where start is high and busy is low, and its result is on the
// rsp_ ports, marked by rsp_valid, for exactly one cycle after it has passed
// the request register and the result register. Lookup, compaction and
// append are done across all slots in parallel, combinationally between the
// request register and the result register, so the rate is one word per cycle.
// busy is high only in the first cycle after reset. Results cannot be held off
// by the receiver; one result is produced for every word taken. Slots hold
// arrival order, oldest in slot 0; a raise into a full table drops slot 0 first.
module keyed_alert_table
   import kat_pkg::*;
#(
   parameter int CAPACITY  = 16,
   parameter int NUM_CODES = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_type,
   input  logic [CODE_W-1:0]    req_alert_code,
   input  logic                 req_active,
   input  logic [SEV_W-1:0]     req_severity,
   input  logic                 req_time_synced,
   input  logic [TIME_W-1:0]    req_time_of_day,
   input  logic [SLOT_W-1:0]    req_read_slot,
   output logic                 rsp_valid,
   output logic [3:0]           rsp_outcome,
   output logic                 rsp_evicted,
   output logic [SLOT_W-1:0]    rsp_slot,
   output logic [CODE_W-1:0]    rsp_entry_code,
   output logic [SEV_W-1:0]     rsp_entry_severity,
   output logic [SEQ_W-1:0]     rsp_entry_sequence,
   output logic                 rsp_entry_time_known,
   output logic [TIME_W-1:0]    rsp_entry_time,
   output logic [CNT_OUT_W-1:0] rsp_fill_level
);

   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int FLAG_W = (NUM_CODES > 1) ? $clog2(NUM_CODES) : 1;

   logic                 busy_ff;
   logic                 req_valid_ff;
   request_type          req_ff;
   entry_type            tbl_ff [CAPACITY];
   entry_type            tbl_in [CAPACITY];
   entry_type            up [CAPACITY];
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [SEQ_W-1:0]     next_seq_ff, next_seq_in;
   logic [NUM_CODES-1:0] flags_ff, flags_in;
   logic                 rsp_valid_ff;
   result_type           rsp_ff, rsp_in;

   logic                 hit;
   logic [IDX_W-1:0]     hit_pos;
   logic                 code_ok;
   logic [FLAG_W-1:0]    flag_idx;
   logic                 suppressed;
   logic                 full;
   logic                 is_report;
   logic                 do_remove, do_update, do_insert;
   logic [IDX_W-1:0]     at;
   logic                 rd_ok;
   logic [IDX_W-1:0]     show_idx;
   entry_type            shown;
   entry_type            new_entry;

   // Accept handshake and request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         req_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         req_valid_ff <= start && !busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      req_ff.kind        <= request_kind_type'(req_type);
      req_ff.alert_code  <= req_alert_code;
      req_ff.active      <= req_active;
      req_ff.severity    <= req_severity;
      req_ff.time_synced <= req_time_synced;
      req_ff.time_of_day <= req_time_of_day;
      req_ff.read_slot   <= req_read_slot;
   end

   kat_lookup #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_kat_lookup (
      .entries (tbl_ff),
      .count   (count_ff),
      .code    (req_ff.alert_code),
      .hit     (hit),
      .pos     (hit_pos)
   );

   // Decode the registered request.
   always_comb begin
      code_ok    = {1'b0, req_ff.alert_code} < (CODE_W + 1)'(NUM_CODES);
      flag_idx   = FLAG_W'(req_ff.alert_code);
      suppressed = code_ok && flags_ff[flag_idx];
      full       = (count_ff == CNT_W'(CAPACITY));
      is_report  = req_valid_ff && (req_ff.kind == REQ_REPORT) && code_ok;
      do_remove  = is_report && !req_ff.active && hit;
      do_update  = is_report && req_ff.active && !suppressed && hit;
      do_insert  = is_report && req_ff.active && !suppressed && !hit;
      at         = full ? IDX_W'(CAPACITY - 1) : IDX_W'(count_ff);
      rd_ok      = (7'(req_ff.read_slot) < 7'(count_ff));
      show_idx   = (req_ff.kind == REQ_READ) ? IDX_W'(req_ff.read_slot) : hit_pos;
      shown      = tbl_ff[show_idx];

      new_entry.code         = req_ff.alert_code;
      new_entry.severity     = req_ff.severity;
      new_entry.sequence_num = next_seq_ff;
      new_entry.time_known   = req_ff.time_synced;
      new_entry.arrival_time = req_ff.time_synced ? req_ff.time_of_day : '0;
   end

   // Next table contents: shift toward slot 0 for removal or eviction,
   // then write the updated or appended entry.
   always_comb begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
         up[i] = tbl_ff[i + 1];
      end
      up[CAPACITY-1] = tbl_ff[CAPACITY-1];

      for (int i = 0; i < CAPACITY; i++) begin
         tbl_in[i] = tbl_ff[i];
         if ((do_remove && (IDX_W'(i) >= hit_pos)) || (do_insert && full)) begin
            tbl_in[i] = up[i];
         end
         if (do_update && (IDX_W'(i) == hit_pos)) begin
            tbl_in[i].severity = req_ff.severity;
         end
         if (do_insert && (IDX_W'(i) == at)) begin
            tbl_in[i] = new_entry;
         end
      end
   end

   // Count, sequence counter and suppression flags.
   always_comb begin
      count_in    = count_ff;
      next_seq_in = next_seq_ff;
      flags_in    = flags_ff;
      if (do_remove) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (do_insert) begin
         next_seq_in = next_seq_ff + SEQ_W'(1);
         if (!full) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (is_report && !req_ff.active) begin
         flags_in[flag_idx] = 1'b0;
      end
      if (req_valid_ff && (req_ff.kind == REQ_SUPPRESS) && code_ok) begin
         flags_in[flag_idx] = 1'b1;
      end
      if (req_valid_ff && (req_ff.kind == REQ_SOFT)) begin
         next_seq_in = SEQ_W'(1);
         flags_in    = '0;
      end
   end

   // Result word.
   always_comb begin
      rsp_in            = '0;
      rsp_in.outcome    = OUT_IGNORED;
      rsp_in.fill_level = CNT_OUT_W'(count_in);
      unique case (req_ff.kind)
         REQ_REPORT: begin
            if (code_ok) begin
               if (!req_ff.active) begin
                  if (hit) begin
                     rsp_in.outcome = OUT_REMOVED;
                     rsp_in.slot    = SLOT_W'(hit_pos);
                     rsp_in.entry   = shown;
                  end else begin
                     rsp_in.outcome = OUT_CLEAR_ABSENT;
                  end
               end else if (suppressed) begin
                  rsp_in.outcome = OUT_HELD;
               end else if (hit) begin
                  rsp_in.outcome        = OUT_UPDATED;
                  rsp_in.slot           = SLOT_W'(hit_pos);
                  rsp_in.entry          = shown;
                  rsp_in.entry.severity = req_ff.severity;
               end else begin
                  rsp_in.outcome = OUT_INSERTED;
                  rsp_in.evicted = full;
                  rsp_in.slot    = SLOT_W'(at);
                  rsp_in.entry   = new_entry;
               end
            end
         end
         REQ_SUPPRESS: begin
            if (code_ok) begin
               rsp_in.outcome = OUT_SUPPRESS_SET;
            end
         end
         REQ_READ: begin
            rsp_in.slot = req_ff.read_slot;
            if (rd_ok) begin
               rsp_in.outcome = OUT_READ_OK;
               rsp_in.entry   = shown;
            end else begin
               rsp_in.outcome = OUT_READ_EMPTY;
            end
         end
         REQ_SOFT: begin
            rsp_in.outcome = OUT_SOFT_RESET;
         end
         default: begin
            rsp_in.outcome = OUT_IGNORED;
         end
      endcase
   end

   // State and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         next_seq_ff  <= SEQ_W'(1);
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         next_seq_ff  <= next_seq_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      tbl_ff <= tbl_in;
      rsp_ff <= rsp_in;
   end

   // Output ports.
   assign busy                 = busy_ff;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_outcome          = rsp_ff.outcome;
   assign rsp_evicted          = rsp_ff.evicted;
   assign rsp_slot             = rsp_ff.slot;
   assign rsp_entry_code       = rsp_ff.entry.code;
   assign rsp_entry_severity   = rsp_ff.entry.severity;
   assign rsp_entry_sequence   = rsp_ff.entry.sequence_num;
   assign rsp_entry_time_known = rsp_ff.entry.time_known;
   assign rsp_entry_time       = rsp_ff.entry.arrival_time;
   assign rsp_fill_level       = rsp_ff.fill_level;

endmodule

// File: design/kat_checker.sv
// Port-level checks for the keyed alert table, bound to its top level.
// Depends on kat_pkg for the outcome codes.
`timescale 1ns / 1ps

module kat_checker
   import kat_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic [3:0]           rsp_outcome,
   input logic                 rsp_evicted,
   input logic [SEQ_W-1:0]     rsp_entry_sequence,
   input logic [CNT_OUT_W-1:0] rsp_fill_level
);

   // Every word taken is followed by a result marked by rsp_valid.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("missing result for an accepted word");

   // An eviction only happens on an append.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted) |-> (rsp_outcome == OUT_INSERTED))
      else $error("eviction reported without an append");

   // Back-to-back results: an append without eviction grows the count by one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid) && (rsp_outcome == OUT_INSERTED) && !rsp_evicted)
      |-> (rsp_fill_level == $past(rsp_fill_level) + 5'd1))
      else $error("entry count did not grow on append");

   // Back-to-back results: a removal shrinks the count by one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid) && (rsp_outcome == OUT_REMOVED))
      |-> (rsp_fill_level == $past(rsp_fill_level) - 5'd1))
      else $error("entry count did not shrink on removal");

   // Back-to-back results: an append right after a soft reset restarts the sequence at one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid) && ($past(rsp_outcome) == OUT_SOFT_RESET)
       && (rsp_outcome == OUT_INSERTED))
      |-> (rsp_entry_sequence == 32'd1))
      else $error("sequence did not restart after soft reset");

endmodule

bind keyed_alert_table kat_checker u_kat_checker (.*);
